// ===== rtl/polyline_normalized_arc_length_macros.svh =====
// Assertion macros shared by the polyline arc length RTL.
`ifndef POLYLINE_NORMALIZED_ARC_LENGTH_MACROS_SVH
`define POLYLINE_NORMALIZED_ARC_LENGTH_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define PNAL_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PNAL_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define PNAL_ASSERT_SAME(label, clk, rst, pre, post, msg)

`define PNAL_ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

// ===== rtl/pnal_pkg.sv =====
// Types and constants for the polyline normalized arc length block.
`timescale 1ns / 1ps

package pnal_pkg;

   localparam int MAX_VERTICES  = 64;
   localparam int COORD_BITS    = 24;
   localparam int FRACTION_BITS = 16;
   localparam int LEN_W         = 32;

   localparam int IDX_W  = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int MAG_W  = COORD_BITS + 1;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int RAD_W  = SQ_W;
   localparam int ROOT_W = MAG_W;
   localparam int QUOT_W = FRACTION_BITS + 1;
   localparam int UNIT_W = (ROOT_W + 2 > LEN_W + 2) ? ROOT_W + 2 : LEN_W + 2;
   localparam int ITER_W = $clog2(UNIT_W + 1);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_coord;
      logic signed [COORD_BITS-1:0] y_coord;
      logic                         last_vertex;
   } pnal_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  vertex_index;
      logic [QUOT_W-1:0] norm_distance;
      logic [LEN_W-1:0]  total_length;
      logic              degenerate;
      logic              overflowed;
      logic              last_result;
   } pnal_rsp_type;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_SQX  = 10'b00_0000_0010,
      ST_SQY  = 10'b00_0000_0100,
      ST_SUM  = 10'b00_0000_1000,
      ST_ROOT = 10'b00_0001_0000,
      ST_ACC  = 10'b00_0010_0000,
      ST_READ = 10'b00_0100_0000,
      ST_LOAD = 10'b00_1000_0000,
      ST_DIV  = 10'b01_0000_0000,
      ST_OUT  = 10'b10_0000_0000
   } pnal_state_type;

endpackage

// ===== rtl/pnal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pnal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/polyline_normalized_arc_length.sv =====
// Polyline chord-length parameterization: cumulative lengths normalized to total.
// Vertex: first stored directly; later: squares, sum, 25-step square root, accumulate.
// Results: read, load, 17-step division on the shared subtractor, output (may stall).
// One vertex or one result at a time; req_stall is high while any work is in flight.
// Synchronous active-high reset clears all control state; the length store is not cleared.
`timescale 1ns / 1ps
`include "polyline_normalized_arc_length_macros.svh"

module polyline_normalized_arc_length
   import pnal_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  pnal_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output pnal_rsp_type rsp_payload
);

   pnal_state_type state_ff, state_in;

   logic signed [COORD_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                         last_ff, last_in;
   logic [MAG_W-1:0]             mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic [SQ_W-1:0]              sq_a_ff, sq_a_in, sq_b_ff, sq_b_in;
   logic [RAD_W-1:0]             rad_ff, rad_in;
   logic [UNIT_W-1:0]            rem_ff, rem_in;
   logic [ROOT_W-1:0]            root_ff, root_in;
   logic [QUOT_W-1:0]            quot_ff, quot_in;
   logic [ITER_W-1:0]            iter_ff, iter_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [LEN_W-1:0]             running_ff, running_in;
   logic                         ovf_ff, ovf_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;

   // datapath helpers
   logic signed [MAG_W-1:0] diff_x, diff_y;
   logic [MAG_W-1:0]        mul_op;
   logic [SQ_W-1:0]         mul_out;
   logic [UNIT_W-1:0]       unit_a, unit_b;
   logic [UNIT_W:0]         unit_diff;
   logic                    unit_take;
   logic [LEN_W:0]          len_sum;
   logic [LEN_W-1:0]        len_sat;
   logic [CNT_W-1:0]        idx_next;
   logic                    degen;
   logic                    is_last_rsp;

   logic             ram_wr_en;
   logic [LEN_W-1:0] ram_wr_data;
   logic [LEN_W-1:0] ram_rd_data;

   pnal_ram #(
      .WIDTH (LEN_W),
      .DEPTH (MAX_VERTICES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign diff_x = MAG_W'(req_payload.x_coord) - MAG_W'(prev_x_ff);
   assign diff_y = MAG_W'(req_payload.y_coord) - MAG_W'(prev_y_ff);

   // one shared squarer
   assign mul_op  = (state_ff == ST_SQX) ? mag_a_ff : mag_b_ff;
   assign mul_out = mul_op * mul_op;

   // one shared compare-and-subtract unit: square root and division steps
   always_comb begin
      unit_a = '0;
      unit_b = '0;
      if (state_ff == ST_ROOT) begin
         unit_a = {rem_ff[UNIT_W-3:0], rad_ff[RAD_W-1 -: 2]};
         unit_b = UNIT_W'({root_ff, 2'b01});
      end else begin
         unit_a = (iter_ff == ITER_W'(FRACTION_BITS)) ? rem_ff : {rem_ff[UNIT_W-2:0], 1'b0};
         unit_b = UNIT_W'(running_ff);
      end
   end

   assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
   assign unit_take = !unit_diff[UNIT_W];

   assign len_sum = {1'b0, running_ff} + (LEN_W + 1)'(root_ff);
   assign len_sat = len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];

   assign idx_next    = CNT_W'({1'b0, idx_ff}) + CNT_W'(1);
   assign is_last_rsp = (idx_next == count_ff);
   assign degen       = (count_ff < CNT_W'(2)) || (running_ff == '0);

   always_comb begin
      state_in   = state_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      last_in    = last_ff;
      mag_a_in   = mag_a_ff;
      mag_b_in   = mag_b_ff;
      sq_a_in    = sq_a_ff;
      sq_b_in    = sq_b_ff;
      rad_in     = rad_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      quot_in    = quot_ff;
      iter_in    = iter_ff;
      count_in   = count_ff;
      running_in = running_ff;
      ovf_in     = ovf_ff;
      idx_in     = idx_ff;
      ram_wr_en   = 1'b0;
      ram_wr_data = running_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in    = req_payload.x_coord;
               y_in    = req_payload.y_coord;
               last_in = req_payload.last_vertex;
               idx_in  = '0;
               if (count_ff >= CNT_W'(MAX_VERTICES)) begin
                  // store full: vertex dropped
                  ovf_in = 1'b1;
                  if (req_payload.last_vertex) begin
                     state_in = ST_READ;
                  end
               end else if (count_ff == '0) begin
                  ram_wr_en = 1'b1;
                  prev_x_in = req_payload.x_coord;
                  prev_y_in = req_payload.y_coord;
                  count_in  = count_ff + CNT_W'(1);
                  if (req_payload.last_vertex) begin
                     state_in = ST_READ;
                  end
               end else begin
                  mag_a_in = diff_x[MAG_W-1] ? MAG_W'(-diff_x) : MAG_W'(diff_x);
                  mag_b_in = diff_y[MAG_W-1] ? MAG_W'(-diff_y) : MAG_W'(diff_y);
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX: begin
            sq_a_in  = mul_out;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sq_b_in  = mul_out;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rad_in   = sq_a_ff + sq_b_ff;
            rem_in   = '0;
            root_in  = '0;
            iter_in  = ITER_W'(ROOT_W - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in  = unit_take ? unit_diff[UNIT_W-1:0] : unit_a;
            root_in = {root_ff[ROOT_W-2:0], unit_take};
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            running_in  = len_sat;
            ram_wr_en   = 1'b1;
            ram_wr_data = len_sat;
            prev_x_in   = x_ff;
            prev_y_in   = y_ff;
            count_in    = count_ff + CNT_W'(1);
            state_in    = last_ff ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            // address goes out now, data is registered by the next cycle
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rem_in   = UNIT_W'(ram_rd_data);
            quot_in  = '0;
            iter_in  = ITER_W'(FRACTION_BITS);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = unit_take ? unit_diff[UNIT_W-1:0] : unit_a;
            quot_in = {quot_ff[QUOT_W-2:0], unit_take};
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (is_last_rsp) begin
                  count_in   = '0;
                  running_in = '0;
                  ovf_in     = 1'b0;
                  prev_x_in  = '0;
                  prev_y_in  = '0;
                  state_in   = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         count_ff   <= '0;
         running_ff <= '0;
         ovf_ff     <= 1'b0;
         idx_ff     <= '0;
         iter_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         count_ff   <= count_in;
         running_ff <= running_in;
         ovf_ff     <= ovf_in;
         idx_ff     <= idx_in;
         iter_ff    <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      last_ff  <= last_in;
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      sq_a_ff  <= sq_a_in;
      sq_b_ff  <= sq_b_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      quot_ff  <= quot_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      rsp_payload.vertex_index  = idx_ff;
      rsp_payload.norm_distance = degen ? '0 : quot_ff;
      rsp_payload.total_length  = running_ff;
      rsp_payload.degenerate    = degen;
      rsp_payload.overflowed    = ovf_ff;
      rsp_payload.last_result   = is_last_rsp;
   end

   `PNAL_ASSERT_SAME(a_idx_in_range, clock, reset, rsp_valid, CNT_W'(idx_ff) < count_ff, "result index beyond stored vertex count")
   `PNAL_ASSERT_SAME(a_frac_bound, clock, reset, rsp_valid, rsp_payload.norm_distance <= QUOT_W'(1 << FRACTION_BITS), "normalized distance above one")
   `PNAL_ASSERT_NEXT(a_run_cleared, clock, reset, rsp_valid && !rsp_stall && rsp_payload.last_result, count_ff == '0 && running_ff == '0 && !ovf_ff, "run state not cleared after final transaction")

endmodule
